### hw/rtl/first_fit_block_allocator_macros.svh
// assertion macros for the first-fit block allocator
// no dependencies; included by the modules that carry checks
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// check on every clock edge outside reset
`define FFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check on every clock edge, reset included
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hw/rtl/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package ffba_pkg;

    // heap geometry
    localparam int HEAP_BYTES   = 1024;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 64;

    // field widths
    localparam int ADDR_W   = 10;
    localparam int SIZE_W   = 16;
    localparam int MARGIN_W = 8;
    localparam int IDX_W    = $clog2(MAX_BLOCKS);
    localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int SPLIT_W  = SIZE_W + 2;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd16;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT,
        S_WR_REM,
        S_WR_HIT,
        S_RESP
    } state_t;

    // input word
    typedef struct packed {
        req_t              req_type;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_offset;
    } in_t;

    // result word
    typedef struct packed {
        logic [ADDR_W-1:0] payload_offset;
        status_t           status;
    } out_t;

    // one block table entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] bytes;
        logic              is_free;
    } entry_t;

    localparam entry_t ENTRY0_INIT = '{
        start:   '0,
        bytes:   ADDR_W'(HEAP_BYTES - HEADER_BYTES),
        is_free: 1'b1
    };

    // controller to datapath
    typedef struct packed {
        logic    req_load;
        logic    scan_init;
        logic    scan_step;
        logic    hit_take;
        logic    shift_init;
        logic    shift_step;
        logic    wr_rem;
        logic    wr_hit;
        logic    res_set;
        status_t res_status;
        logic    out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic null_free;
        logic is_alloc;
        logic hit;
        logic miss;
        logic need_split;
        logic full;
        logic shift_done;
        logic out_free;
    } stat_t;

endpackage

### hw/rtl/ffba_dpath.sv
// datapath: block table memory, scan and shift counters, result register
// depends on ffba_pkg and first_fit_block_allocator_macros.svh
`timescale 1ns / 1ps
`include "first_fit_block_allocator_macros.svh"
module ffba_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [ffba_pkg::MARGIN_W-1:0] cfg_wdata,
    input  ffba_pkg::in_t                 s_data,
    input  ffba_pkg::cmd_t                cmd,
    output ffba_pkg::stat_t               stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ffba_pkg::out_t                m_data
);

    localparam int AW = ffba_pkg::ADDR_W;
    localparam int IW = ffba_pkg::IDX_W;
    localparam int CW = ffba_pkg::CNT_W;
    localparam int PW = ffba_pkg::SPLIT_W;

    ffba_pkg::entry_t blk_mem [ffba_pkg::MAX_BLOCKS];

    logic [ffba_pkg::MARGIN_W-1:0] margin_reg;
    ffba_pkg::in_t                 req_reg;
    logic [CW-1:0]                 total_reg;
    logic [CW-1:0]                 rd_idx_reg;
    logic [IW-1:0]                 chk_idx_reg;
    logic                          chk_vld_reg;
    logic [IW-1:0]                 hit_idx_reg;
    ffba_pkg::entry_t              hit_reg;
    logic                          split_reg;
    logic [IW-1:0]                 shr_reg;
    logic [IW-1:0]                 sh_pidx_reg;
    logic                          sh_pend_reg;
    logic                          init_reg;
    logic                          zero_reg;
    ffba_pkg::entry_t              rd_q_reg;
    ffba_pkg::out_t                res_reg;
    ffba_pkg::out_t                res_next;
    logic                          m_valid_reg;

    ffba_pkg::entry_t rd_data;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    ffba_pkg::entry_t wr_data;
    logic             scan_issue;
    logic             shift_issue;
    logic             is_alloc;
    logic             fits;
    logic             need_split;
    logic [PW-1:0]    split_thr;
    logic [AW:0]      offs_sum;
    logic             hit;

    // entry 0 reads as its reset value until first written
    assign rd_data     = zero_reg ? ffba_pkg::ENTRY0_INIT : rd_q_reg;
    assign is_alloc    = (req_reg.req_type == ffba_pkg::REQ_ALLOC);
    assign scan_issue  = (rd_idx_reg < total_reg);
    assign shift_issue = (shr_reg > hit_idx_reg);

    // fit, split and offset match on the entry under test
    assign fits       = (ffba_pkg::SIZE_W'(rd_data.bytes) >= req_reg.request_size);
    assign split_thr  = PW'(req_reg.request_size) + PW'(ffba_pkg::HEADER_BYTES)
                      + PW'(margin_reg);
    assign need_split = (PW'(rd_data.bytes) > split_thr);
    assign offs_sum   = (AW+1)'(rd_data.start) + (AW+1)'(ffba_pkg::HEADER_BYTES);
    assign hit        = chk_vld_reg && (is_alloc ? (rd_data.is_free && fits)
                                                 : (offs_sum == (AW+1)'(req_reg.release_offset)));

    assign stat.null_free  = !is_alloc && (req_reg.release_offset == '0);
    assign stat.is_alloc   = is_alloc;
    assign stat.hit        = hit;
    assign stat.miss       = !chk_vld_reg && !scan_issue;
    assign stat.need_split = need_split;
    assign stat.full       = (total_reg >= CW'(ffba_pkg::MAX_BLOCKS));
    assign stat.shift_done = !sh_pend_reg && !shift_issue;
    assign stat.out_free   = !m_valid_reg || m_ready;

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = rd_idx_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data = hit_reg;
        if (cmd.scan_step && scan_issue) begin
            rd_en = 1'b1;
        end
        if (cmd.shift_step && shift_issue) begin
            rd_en   = 1'b1;
            rd_addr = shr_reg;
        end
        if (cmd.shift_step && sh_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = sh_pidx_reg + IW'(1);
            wr_data = rd_data;
        end
        if (cmd.wr_rem) begin
            wr_en           = 1'b1;
            wr_addr         = hit_idx_reg + IW'(1);
            wr_data.start   = hit_reg.start + AW'(ffba_pkg::HEADER_BYTES)
                            + req_reg.request_size[AW-1:0];
            wr_data.bytes   = hit_reg.bytes - req_reg.request_size[AW-1:0]
                            - AW'(ffba_pkg::HEADER_BYTES);
            wr_data.is_free = 1'b1;
        end
        if (cmd.wr_hit) begin
            wr_en           = 1'b1;
            wr_addr         = hit_idx_reg;
            wr_data.start   = hit_reg.start;
            wr_data.bytes   = (is_alloc && split_reg) ? req_reg.request_size[AW-1:0]
                                                      : hit_reg.bytes;
            wr_data.is_free = !is_alloc;
        end
    end

    // block table: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            blk_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= blk_mem[rd_addr];
        end
    end

    // result value
    always_comb begin
        res_next.status         = cmd.res_status;
        res_next.payload_offset = '0;
        if (is_alloc && (cmd.res_status == ffba_pkg::ST_OK)) begin
            res_next.payload_offset = hit_reg.start + AW'(ffba_pkg::HEADER_BYTES);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg  <= ffba_pkg::MARGIN_RESET;
            total_reg   <= CW'(1);
            rd_idx_reg  <= '0;
            chk_vld_reg <= 1'b0;
            sh_pend_reg <= 1'b0;
            init_reg    <= 1'b1;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                margin_reg <= cfg_wdata;
            end
            if (cmd.wr_rem) begin
                total_reg <= total_reg + CW'(1);
            end
            if (cmd.scan_init) begin
                rd_idx_reg  <= '0;
                chk_vld_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                chk_vld_reg <= scan_issue;
                if (scan_issue) begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
            end
            if (cmd.shift_init) begin
                sh_pend_reg <= 1'b0;
            end else if (cmd.shift_step) begin
                sh_pend_reg <= shift_issue;
            end
            if (wr_en && (wr_addr == '0)) begin
                init_reg <= 1'b0;
            end
            if (rd_en) begin
                zero_reg <= init_reg && (rd_addr == '0);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_reg <= s_data;
        end
        if (cmd.scan_step) begin
            chk_idx_reg <= rd_idx_reg[IW-1:0];
        end
        if (cmd.hit_take) begin
            hit_idx_reg <= chk_idx_reg;
            hit_reg     <= rd_data;
            split_reg   <= is_alloc && need_split;
        end
        if (cmd.shift_init) begin
            shr_reg <= IW'(total_reg - CW'(1));
        end else if (cmd.shift_step && shift_issue) begin
            shr_reg     <= shr_reg - IW'(1);
            sh_pidx_reg <= shr_reg;
        end
        if (cmd.res_set) begin
            res_reg <= res_next;
        end
        if (cmd.out_load) begin
            m_data <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `FFBA_ASSERT(a_total_range, (total_reg != '0) && (total_reg <= CW'(ffba_pkg::MAX_BLOCKS)), "block count out of range")
    `FFBA_ASSERT(a_hit_checked, cmd.hit_take |-> chk_vld_reg, "hit taken without checked entry")
    `FFBA_ASSERT(a_shift_above_hit, sh_pend_reg |-> (sh_pidx_reg > hit_idx_reg), "shift moved entry at or below hit")
    `FFBA_ASSERT(a_rem_room, cmd.wr_rem |-> (split_reg && (total_reg < CW'(ffba_pkg::MAX_BLOCKS))), "remainder insert without room")

endmodule

### hw/rtl/ffba_ctrl.sv
// controller: sequences scan, shift, table writes and result handoff
// depends on ffba_pkg
`timescale 1ns / 1ps
module ffba_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ffba_pkg::stat_t stat,
    output ffba_pkg::cmd_t  cmd
);

    ffba_pkg::state_t state_reg;
    ffba_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.res_status = ffba_pkg::ST_OK;
        unique case (state_reg)
            ffba_pkg::S_IDLE: begin
                s_ready      = 1'b1;
                cmd.req_load = s_valid;
                if (s_valid) begin
                    state_next = ffba_pkg::S_START;
                end
            end
            ffba_pkg::S_START: begin
                if (stat.null_free) begin
                    cmd.res_set = 1'b1;
                    state_next  = ffba_pkg::S_RESP;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = ffba_pkg::S_SCAN;
                end
            end
            ffba_pkg::S_SCAN: begin
                if (stat.hit) begin
                    if (stat.is_alloc && stat.need_split && stat.full) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ffba_pkg::ST_FULL;
                        state_next     = ffba_pkg::S_RESP;
                    end else if (stat.is_alloc && stat.need_split) begin
                        cmd.hit_take   = 1'b1;
                        cmd.shift_init = 1'b1;
                        state_next     = ffba_pkg::S_SHIFT;
                    end else begin
                        cmd.hit_take = 1'b1;
                        state_next   = ffba_pkg::S_WR_HIT;
                    end
                end else if (stat.miss) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = stat.is_alloc ? ffba_pkg::ST_NOFIT
                                                   : ffba_pkg::ST_UNKNOWN;
                    state_next     = ffba_pkg::S_RESP;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ffba_pkg::S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_done) begin
                    state_next = ffba_pkg::S_WR_REM;
                end
            end
            ffba_pkg::S_WR_REM: begin
                cmd.wr_rem = 1'b1;
                state_next = ffba_pkg::S_WR_HIT;
            end
            ffba_pkg::S_WR_HIT: begin
                cmd.wr_hit  = 1'b1;
                cmd.res_set = 1'b1;
                state_next  = ffba_pkg::S_RESP;
            end
            ffba_pkg::S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ffba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/first_fit_block_allocator.sv
// top level of the first-fit block allocator with block split
// depends on ffba_pkg, ffba_ctrl and ffba_dpath
// usage:
//   s_valid/s_ready/s_data carry one request word: allocate (request_size)
//   or free (release_offset). m_valid/m_ready/m_data return exactly one
//   result word per request: payload offset and a status code.
//   cfg_wen/cfg_wdata write split_margin; write it only while the block is idle.
// sequencing:
//   one request at a time. a free of offset 0 skips the scan and goes
//   straight to the result. otherwise the scan checks one entry a cycle
//   on the registered read port until it hits or runs past the last entry.
//   a split shifts the entries above the hit up by one, one a cycle, plus
//   two table writes: the remainder entry, then the hit entry.
// reset:
//   aresetn low for one clock leaves one free block covering the whole heap
//   and split_margin at 16; no clearing pass is needed.
// stall:
//   a result waits in the output register while m_ready is low; a new
//   request is taken once the previous result has moved there.
`timescale 1ns / 1ps
module first_fit_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [ffba_pkg::MARGIN_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ffba_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ffba_pkg::out_t                m_data
);

    ffba_pkg::cmd_t  cmd;
    ffba_pkg::stat_t stat;

    // state machine
    ffba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // block table and result path
    ffba_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
